>>> hw/rtl/fle_pkg.sv
// ----------------------------------------------------------------------------
// fle_pkg
// Shared constants and types for the fixed-capacity list engine.
// ----------------------------------------------------------------------------
package fle_pkg;

	localparam int DEPTH = 16;
	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PH_W  = $clog2(DEPTH);
	localparam int IDX_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_DROP   = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_ERASE  = 3'd3,
		CMD_FIND   = 3'd4,
		CMD_CLEAR  = 3'd5,
		CMD_SORT   = 3'd6,
		CMD_READ   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// per-cell load select
	typedef enum logic [2:0] {
		SEL_HOLD,
		SEL_LOAD,
		SEL_LEFT,
		SEL_RIGHT,
		SEL_SORT_LO,
		SEL_SORT_HI
	} cell_sel_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SORT
	} fsm_t;

endpackage

>>> hw/rtl/fixed_capacity_list_engine.sv
// ----------------------------------------------------------------------------
// fixed_capacity_list_engine
// List of up to DEPTH (16) words with a live count, kept in a chain of cells.
// A request is taken when start is high and busy is low. Every command but
// sort answers with a one-cycle done pulse on the cycle after it is taken.
// Sort runs DEPTH (16) odd-even compare-exchange phases across the cell chain,
// holding busy high while the phases run, and pulses done in the cycle after
// the last phase. Results are shown for the single cycle that done is high;
// the receiver cannot stall them.
// ----------------------------------------------------------------------------
module fixed_capacity_list_engine import fle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	input  logic [4:0]  drop_count,
	output logic        done,
	output logic [1:0]  status,
	output logic        found,
	output logic [4:0]  result_index,
	output logic [31:0] read_data,
	output logic [4:0]  entry_count
);

	cell_sel_t        sel [DEPTH];
	logic [WIDTH-1:0] word [DEPTH];
	logic [DEPTH-1:0] match;
	logic [WIDTH-1:0] key;
	logic [WIDTH-1:0] rd_word;

	assign key     = WIDTH'(value);
	assign rd_word = word[IDX_W'(position)];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WIDTH-1:0] left_w;
		logic [WIDTH-1:0] right_w;
		if (g == 0) begin : g_lo
			assign left_w = '0;
		end else begin : g_lo
			assign left_w = word[g-1];
		end
		if (g == DEPTH - 1) begin : g_hi
			assign right_w = '0;
		end else begin : g_hi
			assign right_w = word[g+1];
		end
		fle_cell u_cell (
			.clk   (clk),
			.sel   (sel[g]),
			.value (key),
			.left  (left_w),
			.right (right_w),
			.word  (word[g]),
			.match (match[g])
		);
	end

	fle_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.position     (position),
		.drop_count   (drop_count),
		.match        (match),
		.rd_word      (rd_word),
		.sel          (sel),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.found        (found),
		.result_index (result_index),
		.read_data    (read_data),
		.entry_count  (entry_count)
	);

endmodule

>>> hw/rtl/fle_cell.sv
// ----------------------------------------------------------------------------
// fle_cell
// One list slot: holds a word, loads from the request, a neighbor or the
// compare-exchange with a neighbor, and flags a match against the key.
// ----------------------------------------------------------------------------
module fle_cell import fle_pkg::*; (
	input  logic             clk,
	input  cell_sel_t        sel,
	input  logic [WIDTH-1:0] value,
	input  logic [WIDTH-1:0] left,
	input  logic [WIDTH-1:0] right,
	output logic [WIDTH-1:0] word,
	output logic             match
);

	logic [WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		case (sel)
			SEL_LOAD:    word_q <= value;
			SEL_LEFT:    word_q <= left;
			SEL_RIGHT:   word_q <= right;
			SEL_SORT_LO: word_q <= (word_q > right) ? right : word_q;
			SEL_SORT_HI: word_q <= (left > word_q) ? left : word_q;
			default:     word_q <= word_q;
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == value);

endmodule

>>> hw/rtl/fle_ctrl.sv
// ----------------------------------------------------------------------------
// fle_ctrl
// Command decode, live count, sort phase sequencer, per-cell selects and
// result registers.
// ----------------------------------------------------------------------------
module fle_ctrl import fle_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       command,
	input  logic [3:0]       position,
	input  logic [4:0]       drop_count,
	input  logic [DEPTH-1:0] match,
	input  logic [WIDTH-1:0] rd_word,
	output cell_sel_t        sel [DEPTH],
	output logic             busy,
	output logic             done,
	output logic [1:0]       status,
	output logic             found,
	output logic [4:0]       result_index,
	output logic [31:0]      read_data,
	output logic [4:0]       entry_count
);

	fsm_t             state_q, state_d;
	logic [PH_W-1:0]  phase_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic             done_q, done_d;
	status_t          status_q, status_d;
	logic             found_q, found_d;
	logic [CNT_W-1:0] ridx_q, ridx_d;
	logic [WIDTH-1:0] rdata_q, rdata_d;
	logic             accept;
	logic             last_phase;
	cmd_t             cmd;

	assign cmd        = cmd_t'(command);
	assign busy       = (state_q == FSM_SORT);
	assign accept     = start && !busy;
	assign last_phase = (phase_q == PH_W'(DEPTH - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept && cmd == CMD_SORT)
					state_d = FSM_SORT;
			end
			FSM_SORT: begin
				if (last_phase)
					state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		int  cnt;
		int  pos;
		int  drp;
		cnt      = int'(count_q);
		pos      = int'(position);
		drp      = int'(drop_count);
		count_d  = count_q;
		done_d   = 1'b0;
		status_d = ST_OK;
		found_d  = 1'b0;
		ridx_d   = '0;
		rdata_d  = '0;
		for (int i = 0; i < DEPTH; i++)
			sel[i] = SEL_HOLD;

		if (busy) begin
			for (int i = 0; i < DEPTH; i++) begin
				if ((i % 2) == int'(phase_q[0]) && (i + 1) < cnt)
					sel[i] = SEL_SORT_LO;
				else if (i >= 1 && ((i - 1) % 2) == int'(phase_q[0]) && i < cnt)
					sel[i] = SEL_SORT_HI;
			end
			done_d = last_phase;
		end else if (accept) begin
			done_d = (cmd != CMD_SORT);
			case (cmd)
				CMD_APPEND: begin
					if (cnt >= DEPTH)
						status_d = ST_FULL;
					else begin
						for (int i = 0; i < DEPTH; i++)
							if (i == cnt)
								sel[i] = SEL_LOAD;
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_DROP: begin
					if (drp >= cnt)
						count_d = '0;
					else
						count_d = count_q - CNT_W'(drop_count);
				end
				CMD_INSERT: begin
					if (cnt >= DEPTH)
						status_d = ST_FULL;
					else if (pos > cnt)
						status_d = ST_RANGE;
					else begin
						for (int i = 0; i < DEPTH; i++) begin
							if (i == pos)
								sel[i] = SEL_LOAD;
							else if (i > pos && i <= cnt)
								sel[i] = SEL_LEFT;
						end
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_ERASE: begin
					if (pos >= cnt || pos >= DEPTH)
						status_d = ST_RANGE;
					else begin
						for (int i = 0; i < DEPTH; i++)
							if (i >= pos && (i + 1) < cnt)
								sel[i] = SEL_RIGHT;
						count_d = count_q - CNT_W'(1);
					end
				end
				CMD_FIND: begin
					ridx_d = count_q;
					for (int i = DEPTH - 1; i >= 0; i--) begin
						if (match[i] && i < cnt) begin
							found_d = 1'b1;
							ridx_d  = CNT_W'(i);
						end
					end
				end
				CMD_CLEAR: count_d = '0;
				CMD_READ: begin
					if (pos >= DEPTH)
						status_d = ST_RANGE;
					else
						rdata_d = rd_word;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			phase_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			if (accept)
				phase_q <= '0;
			else if (busy)
				phase_q <= phase_q + PH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		found_q  <= found_d;
		ridx_q   <= ridx_d;
		rdata_q  <= rdata_d;
	end

	assign done         = done_q;
	assign status       = status_q;
	assign found        = found_q;
	assign result_index = 5'(ridx_q);
	assign read_data    = 32'(rdata_q);
	assign entry_count  = 5'(count_q);

endmodule
